### design/ulasm_pkg.sv
// Shared constants, types and control structs for the UART receive line assembler.
package ulasm_pkg;

  // Receive ring depth and longest line kept.
  localparam int FIFO_DEPTH = 64;
  localparam int LINE_MAX   = 32;

  // Derived widths.
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int LA_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LEN_W  = $clog2(LINE_MAX + 1);

  // Fixed field widths of the stream words.
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;

  // Character codes the assembler reacts to.
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  // Input item selector carried on the slave tuser.
  localparam logic FUNC_RECEIVE = 1'b0;
  localparam logic FUNC_PROCESS = 1'b1;

  // Result kind carried on the master tuser.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_CHAR   = 1'b1;

  // Requests to the receive ring.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] data;
  } fifo_cmd_t;

  // Receive ring status.
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             ovf;
    logic             empty;
  } fifo_stat_t;

  // Requests to the line store.
  typedef struct packed {
    logic              clear;
    logic              append;
    logic [BYTE_W-1:0] ch;
    logic              rd_en;
    logic [LA_W-1:0]   rd_addr;
  } line_cmd_t;

endpackage

### design/ulasm_fifo.sv
// Receive ring FIFO: byte memory, read pointer, fill count and sticky overflow flag.
module ulasm_fifo
  import ulasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  fifo_cmd_t         cmd,
  output fifo_stat_t        stat,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int SUM_W = PTR_W + 2;

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              ovf;
  logic [SUM_W-1:0]  wr_sum;
  logic [PTR_W-1:0]  wr_addr;
  logic              full;

  // Write slot is read pointer plus fill, wrapped once; a full ring lands on the read pointer.
  always_comb begin
    wr_sum = SUM_W'(rd_ptr) + SUM_W'(fill);
    if (wr_sum >= SUM_W'(FIFO_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(FIFO_DEPTH);
    end
    wr_addr = wr_sum[PTR_W-1:0];
    full    = (fill == CNT_W'(FIFO_DEPTH));
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Pointer, count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      fill   <= '0;
      ovf    <= 1'b0;
    end else if (cmd.push) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        fill <= fill + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      fill <= fill - CNT_W'(1);
      if (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) begin
        rd_ptr <= '0;
      end else begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  assign stat.fill  = fill;
  assign stat.ovf   = ovf;
  assign stat.empty = (fill == '0);

endmodule

### design/ulasm_line.sv
// Line store: character memory and current line length.
module ulasm_line
  import ulasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  line_cmd_t         cmd,
  output logic [LEN_W-1:0]  len,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [LINE_MAX];
  logic              room;

  // Characters beyond the line limit are dropped.
  assign room = (len < LEN_W'(LINE_MAX));

  // Memory write at the current length and registered read.
  always_ff @(posedge clk) begin
    if (cmd.append && room) begin
      mem[len[LA_W-1:0]] <= cmd.ch;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  // Line length.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.clear) begin
      len <= '0;
    end else if (cmd.append && room) begin
      len <= len + LEN_W'(1);
    end
  end

endmodule

### design/uart_rx_line_assembler.sv
// Top level: UART receive ring FIFO feeding a line assembler, with stream ports.
//
//  Port group  Dir  Payload
//  s_*         in   tuser = func, tdata[7:0] = rx_byte
//  m_*         out  tuser = kind, tlast = last,
//                   tdata[7:0] = line_char, [14:8] = fifo_count, [15] = overflowed
//
// A receive item goes through the status state, which loads the status word into the
// output register; a process item first passes the pop state for the FIFO memory read
// (skipped when the FIFO is empty). A completed line is emitted one character at a time,
// each by a line memory read state, then an output load state; no input is taken
// meanwhile.
// Reset is synchronous; the FIFO and line memories are not cleared and need no pass.
// A stalled output holds the state machine in its load state until the word is taken.
module uart_rx_line_assembler
  import ulasm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] line_char, [14:8] fifo_count, [15] overflowed
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_STAT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  state_t            state;
  state_t            state_next;
  fifo_cmd_t         fifo_cmd;
  fifo_stat_t        fifo_stat;
  logic [BYTE_W-1:0] fifo_rd;
  line_cmd_t         line_cmd;
  logic [LEN_W-1:0]  line_len;
  logic [BYTE_W-1:0] line_rd;
  logic [LA_W-1:0]   emit_idx;
  logic [LEN_W-1:0]  emit_n;
  logic              emit_last;
  logic              accept;
  logic              slot_free;
  logic              out_load;
  logic              out_valid;
  logic              out_kind;
  logic              out_last;
  logic [BYTE_W-1:0] out_char;
  logic [COUNT_W-1:0] out_count;
  logic              out_ovf;

  ulasm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .cmd     (fifo_cmd),
    .stat    (fifo_stat),
    .rd_data (fifo_rd)
  );

  ulasm_line u_line (
    .clk     (clk),
    .rst     (rst),
    .cmd     (line_cmd),
    .len     (line_len),
    .rd_data (line_rd)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;
  assign out_load  = slot_free && (state == ST_STAT || state == ST_EMIT_WR);
  assign emit_last = ((LEN_W'(emit_idx) + LEN_W'(1)) == emit_n);

  // Requests to the ring and line store, and the next state.
  always_comb begin
    fifo_cmd         = '0;
    fifo_cmd.data    = s_tdata;
    line_cmd         = '0;
    line_cmd.ch      = fifo_rd;
    line_cmd.rd_addr = emit_idx;
    state_next       = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == FUNC_RECEIVE) begin
            fifo_cmd.push = 1'b1;
            state_next    = ST_STAT;
          end else if (fifo_stat.empty) begin
            // An empty FIFO yields NUL, which discards the partial line.
            line_cmd.clear = 1'b1;
            state_next     = ST_STAT;
          end else begin
            fifo_cmd.pop = 1'b1;
            state_next   = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (fifo_rd inside {CH_LF, CH_CR}) begin
          line_cmd.clear = 1'b1;
          state_next     = (line_len != '0) ? ST_EMIT_RD : ST_STAT;
        end else if (fifo_rd == CH_NUL) begin
          line_cmd.clear = 1'b1;
          state_next     = ST_STAT;
        end else begin
          line_cmd.append = 1'b1;
          state_next      = ST_STAT;
        end
      end
      ST_STAT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        line_cmd.rd_en = 1'b1;
        state_next     = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, line emission counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      emit_idx  <= '0;
      emit_n    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_POP: begin
          emit_idx <= '0;
          emit_n   <= line_len;
        end
        ST_STAT: begin
          if (slot_free) begin
            out_kind  <= KIND_STATUS;
            out_char  <= CH_NUL;
            out_last  <= 1'b1;
            out_count <= COUNT_W'(fifo_stat.fill);
            out_ovf   <= fifo_stat.ovf;
          end
        end
        ST_EMIT_WR: begin
          if (slot_free) begin
            out_kind  <= KIND_CHAR;
            out_char  <= line_rd;
            out_last  <= emit_last;
            out_count <= COUNT_W'(fifo_stat.fill);
            out_ovf   <= fifo_stat.ovf;
            emit_idx  <= emit_idx + LA_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_ovf, out_count, out_char};

  // A status word is always a single word with a zero character.
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STATUS) |-> (m_tlast && m_tdata[7:0] == CH_NUL))
    else $error("status word with character or without last");

  // The reported count never exceeds the ring depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:8] <= COUNT_W'(FIFO_DEPTH)))
    else $error("FIFO count beyond depth");

  // Overflow is sticky until reset.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.ovf |=> fifo_stat.ovf)
    else $error("overflow flag cleared without reset");

  // Input is never taken while a line is being emitted.
  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD || state == ST_EMIT_WR) |-> !s_tready)
    else $error("input ready during line emission");

endmodule

### bench/line_assembly_checker.sv
// Checker that predicts the line assembler's output words and compares them as they leave.
`timescale 1ns / 1ps
module line_assembly_checker
  import ulasm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [7:0] line_char, [14:8] fifo_count, [15] overflowed
  input  logic        m_tuser,   // [0] kind
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  // One output word, split into its fields.
  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } out_word_t;

  // Predicted state of the receive ring and the line being built.
  logic [BYTE_W-1:0] ring [FIFO_DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              ovf_seen;
  logic [BYTE_W-1:0] line_buf [LINE_MAX];
  logic [LEN_W-1:0]  line_len;
  out_word_t         due_words [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Every word carries the ring count and overflow flag as they stand after the step.
  function automatic void queue_word(input logic kind, input logic [BYTE_W-1:0] ch,
                                     input logic last);
    out_word_t w;
    w.kind  = kind;
    w.ch    = ch;
    w.last  = last;
    w.count = COUNT_W'(fill);
    w.ovf   = ovf_seen;
    due_words.push_back(w);
  endfunction

  // Work out the words that one accepted input word causes.
  function automatic void assemble_step(input logic func, input logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] c;
    logic [PTR_W-1:0]  wr_idx;
    int                n;
    if (func == FUNC_RECEIVE) begin
      // A full ring overwrites the slot at the read pointer, so it is popped next.
      wr_idx = rd_ptr + fill[PTR_W-1:0];
      ring[wr_idx] = rx;
      if (fill == CNT_W'(FIFO_DEPTH)) ovf_seen = 1'b1;
      else fill = fill + 1'b1;
      queue_word(KIND_STATUS, '0, 1'b1);
    end else begin
      // An empty ring yields NUL.
      if (fill == '0) begin
        c = CH_NUL;
      end else begin
        c      = ring[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        fill   = fill - 1'b1;
      end
      if ((c == CH_LF || c == CH_CR) && line_len != '0) begin
        n        = int'(line_len);
        line_len = '0;
        for (int i = 0; i < n; i++) queue_word(KIND_CHAR, line_buf[i], i == n - 1);
      end else begin
        if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
          line_len = '0;
        end else if (line_len < LEN_W'(LINE_MAX)) begin
          line_buf[line_len[LA_W-1:0]] = c;
          line_len = line_len + 1'b1;
        end
        queue_word(KIND_STATUS, '0, 1'b1);
      end
    end
  endfunction

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("%0d ns: %s", $time, what);
    errors++;
  endtask

  // Predict on each accepted input word, compare each accepted output word.
  always @(posedge clk) begin : watch
    out_word_t got;
    out_word_t want;
    string     bad;
    if (rst) begin
      rd_ptr   = '0;
      fill     = '0;
      ovf_seen = 1'b0;
      line_len = '0;
      due_words.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) assemble_step(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind  = m_tuser;
        got.ch    = m_tdata[7:0];
        got.last  = m_tlast;
        got.count = m_tdata[14:8];
        got.ovf   = m_tdata[15];
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d char %h last %0d count %0d ovf %0d",
                                    got.kind, got.ch, got.last, got.count, got.ovf));
        end else begin
          want = due_words.pop_front();
          bad  = "";
          if (got.kind != want.kind)
            bad = {bad, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
          if (got.ch != want.ch)
            bad = {bad, $sformatf(" char %h/%h", got.ch, want.ch)};
          if (got.last != want.last)
            bad = {bad, $sformatf(" last %0d/%0d", got.last, want.last)};
          if (got.count != want.count)
            bad = {bad, $sformatf(" count %0d/%0d", got.count, want.count)};
          if (got.ovf != want.ovf)
            bad = {bad, $sformatf(" ovf %0d/%0d", got.ovf, want.ovf)};
          if (bad != "") report_mismatch({"word mismatch (got/want):", bad});
        end
      end
      pending <= due_words.size();
    end
  end

endmodule

### bench/tb_top.sv
// Top of the line assembler testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ulasm_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] rx_byte
  logic        s_tuser;   // [0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] line_char, [14:8] fifo_count, [15] overflowed
  logic        m_tuser;   // [0] kind
  logic        m_tlast;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          cyc = 0;
  int          sent = 0;

  uart_rx_line_assembler uut (.*);
  line_assembly_checker chk (.*);

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output back-pressure: random stalls, none during one long stretch.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= 300 && cyc < 700) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 99) >= 12);
  end

  // End the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word and hold it until taken; valid stays high but for random gaps.
  task automatic send_word(input logic func, input logic [7:0] rx);
    if (sent < 60 || sent >= 110) begin
      while ($urandom_range(0, 99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Stop sending until every predicted word has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A random byte that is not a line control character.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_LF || b == CH_CR || b == CH_NUL) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Stimulus: directed cases first, then a ring overrun that carries an over-long line.
  initial begin
    logic [7:0] b;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= FUNC_RECEIVE;
    m_tready <= 1'b0;
    rst      <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Process with an empty ring takes NUL.
    send_word(FUNC_PROCESS, 8'hFF);
    // Line ender with nothing stored gives a status word.
    send_word(FUNC_RECEIVE, CH_LF);
    send_word(FUNC_PROCESS, 8'h00);
    // A three-character line with extreme bytes, ended by CR.
    send_word(FUNC_RECEIVE, 8'h41);
    send_word(FUNC_RECEIVE, 8'hFF);
    send_word(FUNC_RECEIVE, 8'h80);
    send_word(FUNC_RECEIVE, CH_CR);
    repeat (4) send_word(FUNC_PROCESS, 8'h00);
    // A partial line discarded by NUL, then an ender with an empty line.
    send_word(FUNC_RECEIVE, 8'h01);
    send_word(FUNC_RECEIVE, 8'h7F);
    send_word(FUNC_RECEIVE, CH_NUL);
    send_word(FUNC_RECEIVE, CH_LF);
    repeat (4) send_word(FUNC_PROCESS, 8'h00);
    // A one-character line ended by LF.
    send_word(FUNC_RECEIVE, 8'h55);
    send_word(FUNC_RECEIVE, CH_LF);
    repeat (2) send_word(FUNC_PROCESS, 8'h00);
    wait_drained();

    // Fill the ring with text, a CR and random bytes; the first slot is overwritten below.
    for (int k = 0; k < FIFO_DEPTH; k++) begin
      if (k >= 1 && k <= LINE_MAX) b = text_byte();
      else if (k == LINE_MAX + 1) b = CH_CR;
      else b = 8'($urandom_range(0, 255));
      send_word(FUNC_RECEIVE, b);
    end
    // One more byte overruns the full ring and lands in the slot popped next.
    send_word(FUNC_RECEIVE, text_byte());
    // Pop a line one character longer than the line store, then its CR.
    repeat (LINE_MAX + 2) send_word(FUNC_PROCESS, 8'h00);

    // Wait for the last words and a few cycles more for anything stray.
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
